// ===== hdl/lmoc_pkg.sv =====
// Shared constants for the loop-matching opcode compressor.
// Opcode, error and kind codes, command characters and default sizes.
// No dependencies.
package lmoc_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int NEST_DEPTH_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 12;
  localparam int OP_W   = 3;
  localparam int OPND_W = 17;
  localparam int ERR_W  = 2;

  localparam logic [OP_W-1:0] OP_LEFT  = 3'd0;
  localparam logic [OP_W-1:0] OP_RIGHT = 3'd1;
  localparam logic [OP_W-1:0] OP_INC   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd3;
  localparam logic [OP_W-1:0] OP_OUT   = 3'd4;
  localparam logic [OP_W-1:0] OP_IN    = 3'd5;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd6;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd7;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NESTING   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

endpackage

// ===== hdl/lmoc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read data updates only when read enable is high. No dependencies.
module lmoc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/loop_matching_opcode_compressor_core.sv =====
// Top level of the loop-matching opcode compressor.
// Depends on lmoc_pkg and lmoc_ram (label stack).
//
// Usage: source bytes enter on in_valid/in_ready, one per accepted item.
// Bytes that are not one of the eight command characters are taken and
// dropped without a result. Every command gives one result item on the
// out_ channel, a matched close bracket gives two: the patch of its open bracket,
// then its own instruction. out_last_of_run marks the final result of a byte.
// A taken byte is registered in the holding stage, with the label stack read,
// and then loaded into the output register.
// Throughput: one byte per cycle while the receiver does not stall; a close
// bracket holds the output register for both its results, so a stream of
// them is held back by the single output register. The open-bracket
// addresses sit in one RAM of NEST_DEPTH entries; a push and a pop in
// adjacent cycles need no bypass: the RAM write lands before the following read.
// Reset clears the program length, last opcode and count and the stack depth;
// the stack RAM is not cleared and no entry is read before it is pushed.
// When the receiver stalls, one decoded item waits in a holding stage and
// in_ready drops once both it and the output register are full.
module loop_matching_opcode_compressor_core #(
  parameter int STORE_DEPTH = lmoc_pkg::STORE_DEPTH_DEF,
  parameter int NEST_DEPTH  = lmoc_pkg::NEST_DEPTH_DEF,
  parameter int COUNT_WIDTH = lmoc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lmoc_pkg::BYTE_W-1:0]       in_source_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [lmoc_pkg::ADDR_W-1:0]       out_write_address,
  output logic [lmoc_pkg::OP_W-1:0]         out_opcode,
  output logic signed [lmoc_pkg::OPND_W-1:0] out_operand,
  output logic [lmoc_pkg::ERR_W-1:0]        out_error_code,
  output logic                              out_last_of_run
);

  import lmoc_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int PLW = $clog2(STORE_DEPTH + 1);
  localparam int NAW = $clog2(NEST_DEPTH);
  localparam int DW  = $clog2(NEST_DEPTH + 1);
  localparam int CW  = COUNT_WIDTH;

  typedef struct packed {
    logic              kind;
    logic [OP_W-1:0]   opcode;
    logic [ERR_W-1:0]  err;
    logic [AW-1:0]     addr;
    logic [OPND_W-1:0] operand;
    logic              close;
  } pend_t;

  logic [PLW-1:0] plen_r;
  logic [OP_W-1:0] prev_op_r;
  logic [CW-1:0]  count_r;
  logic [DW-1:0]  depth_r;

  logic  pend_v_r;
  pend_t pend_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [OP_W-1:0]   out_op_r;
  logic [OPND_W-1:0] out_opnd_r;
  logic [ERR_W-1:0]  out_err_r;
  logic              out_last_r;
  logic              second_r;
  logic [AW-1:0]     sec_here_r;
  logic [AW-1:0]     sec_target_r;

  logic            cmd;
  logic [OP_W-1:0] op;
  logic            take;
  logic            merge, unmatched, full, nest, is_err;
  logic            push, pop, new_instr;
  logic [CW-1:0]   count_inc;
  logic [AW-1:0]   here;
  pend_t           pend_nxt;
  logic            out_free, out_load;
  logic [AW-1:0]   stack_rdata;

  always_comb begin
    cmd = 1'b1;
    op  = OP_LEFT;
    case (in_source_byte)
      CH_LEFT:  op = OP_LEFT;
      CH_RIGHT: op = OP_RIGHT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  cmd = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || (out_ready && !second_r);
  assign out_load = pend_v_r && out_free;
  assign in_ready = !pend_v_r || out_free;
  assign take     = in_valid && in_ready && cmd;

  assign here      = AW'(plen_r);
  assign count_inc = (count_r == {CW{1'b1}}) ? count_r : count_r + CW'(1);
  assign merge     = (op <= OP_DEC) && (plen_r != '0) && (op == prev_op_r);
  assign unmatched = !merge && (op == OP_CLOSE) && (depth_r == '0);
  assign full      = !merge && !unmatched && (plen_r == PLW'(STORE_DEPTH));
  assign nest      = !merge && !full && (op == OP_OPEN) && (depth_r == DW'(NEST_DEPTH));
  assign is_err    = unmatched || full || nest;
  assign new_instr = !merge && !is_err;
  assign push      = take && new_instr && (op == OP_OPEN);
  assign pop       = take && new_instr && (op == OP_CLOSE);

  always_comb begin
    pend_nxt.kind    = is_err ? KIND_ERROR : KIND_WRITE;
    pend_nxt.opcode  = op;
    pend_nxt.close   = pop;
    pend_nxt.err     = ERR_NONE;
    pend_nxt.addr    = here;
    pend_nxt.operand = OPND_W'(1);
    if (merge) begin
      pend_nxt.addr    = AW'(plen_r - PLW'(1));
      pend_nxt.operand = OPND_W'(count_inc);
    end else if (is_err) begin
      pend_nxt.addr    = '0;
      pend_nxt.operand = '0;
      pend_nxt.err     = unmatched ? ERR_UNMATCHED : (full ? ERR_FULL : ERR_NESTING);
    end else if (op == OP_OPEN) begin
      pend_nxt.operand = {OPND_W{1'b1}};
    end
  end

  lmoc_ram #(
    .WIDTH (AW),
    .DEPTH (NEST_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (NAW'(depth_r)),
    .wdata (here),
    .re    (pop),
    .raddr (NAW'(depth_r - DW'(1))),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= '0;
      prev_op_r <= OP_LEFT;
      count_r   <= '0;
      depth_r   <= '0;
    end else if (take) begin
      if (merge) begin
        count_r <= count_inc;
      end else if (new_instr) begin
        plen_r    <= plen_r + PLW'(1);
        prev_op_r <= op;
        count_r   <= CW'(1);
        if (push) begin
          depth_r <= depth_r + DW'(1);
        end else if (pop) begin
          depth_r <= depth_r - DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (take) begin
      pend_v_r <= 1'b1;
    end else if (out_load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      second_r    <= pend_r.close;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= second_r;
      second_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= pend_r.kind;
      out_err_r  <= pend_r.err;
      if (pend_r.close) begin
        out_addr_r   <= ADDR_W'(stack_rdata);
        out_op_r     <= OP_OPEN;
        out_opnd_r   <= OPND_W'(pend_r.addr);
        out_last_r   <= 1'b0;
        sec_here_r   <= pend_r.addr;
        sec_target_r <= stack_rdata;
      end else begin
        out_addr_r <= ADDR_W'(pend_r.addr);
        out_op_r   <= pend_r.opcode;
        out_opnd_r <= pend_r.operand;
        out_last_r <= 1'b1;
      end
    end else if (out_valid_r && out_ready && second_r) begin
      out_addr_r <= ADDR_W'(sec_here_r);
      out_op_r   <= OP_CLOSE;
      out_opnd_r <= OPND_W'(sec_target_r);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_write_address = out_addr_r;
  assign out_opcode        = out_op_r;
  assign out_operand       = out_opnd_r;
  assign out_error_code    = out_err_r;
  assign out_last_of_run   = out_last_r;

  a_patch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && second_r) |-> (!out_last_r && out_op_r == OP_OPEN))
    else $error("patch beat flagged as last or not an open bracket");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(NEST_DEPTH))
    else $error("label stack depth past its bound");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= PLW'(STORE_DEPTH))
    else $error("program length past store depth");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (pend_v_r && out_valid_r))
    else $error("input stalled with a free stage");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for loop_matching_opcode_compressor_core.
// A scoreboard class predicts every store write and error report from the accepted
// source bytes; depends on lmoc_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmoc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [OP_W-1:0]   op;
    logic [OPND_W-1:0] operand;
    logic [ERR_W-1:0]  err;
    logic              last;
  } store_write_t;

  function automatic bit decode_command(input logic [BYTE_W-1:0] ch,
                                        output logic [OP_W-1:0] op);
    decode_command = 1'b1;
    op = OP_LEFT;
    case (ch)
      CH_LEFT:  op = OP_LEFT;
      CH_RIGHT: op = OP_RIGHT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  decode_command = 1'b0;
    endcase
  endfunction

  class compile_checker;
    int unsigned       prog_len = 0;
    logic [OP_W-1:0]   last_op = OP_LEFT;
    int unsigned       last_count = 0;
    logic [ADDR_W-1:0] open_addr [NEST_DEPTH_DEF];
    int unsigned       open_depth = 0;
    store_write_t      pending_writes[$];
    int                failures = 0;
    int                checked = 0;
    int                bytes_taken = 0;
    int                errors_expected = 0;
    int                deepest = 0;

    function void add(input logic kind, input logic [ADDR_W-1:0] addr,
                      input logic [OP_W-1:0] op, input logic [OPND_W-1:0] operand,
                      input logic [ERR_W-1:0] err, input logic last);
      store_write_t w;
      w.kind = kind;
      w.addr = addr;
      w.op = op;
      w.operand = operand;
      w.err = err;
      w.last = last;
      if (kind == KIND_ERROR) errors_expected++;
      pending_writes.push_back(w);
    endfunction

    function void take_byte(input logic [BYTE_W-1:0] ch);
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] here;
      logic [ADDR_W-1:0] target;
      bytes_taken++;
      if (!decode_command(ch, op)) return;
      here = ADDR_W'(prog_len);
      if (op <= OP_DEC && prog_len > 0 && op == last_op) begin
        if (last_count < (1 << COUNT_WIDTH_DEF) - 1) last_count++;
        add(KIND_WRITE, ADDR_W'(prog_len - 1), op, OPND_W'(last_count), ERR_NONE, 1'b1);
      end else if (op == OP_CLOSE && open_depth == 0) begin
        add(KIND_ERROR, '0, op, '0, ERR_UNMATCHED, 1'b1);
      end else if (prog_len >= STORE_DEPTH_DEF) begin
        add(KIND_ERROR, '0, op, '0, ERR_FULL, 1'b1);
      end else if (op <= OP_IN) begin
        prog_len++;
        last_op = op;
        last_count = 1;
        add(KIND_WRITE, here, op, OPND_W'(1), ERR_NONE, 1'b1);
      end else if (op == OP_OPEN) begin
        if (open_depth >= NEST_DEPTH_DEF) begin
          add(KIND_ERROR, '0, op, '0, ERR_NESTING, 1'b1);
        end else begin
          open_addr[open_depth] = here;
          open_depth++;
          if (open_depth > deepest) deepest = open_depth;
          prog_len++;
          last_op = op;
          last_count = 1;
          add(KIND_WRITE, here, op, {OPND_W{1'b1}}, ERR_NONE, 1'b1);
        end
      end else begin
        open_depth--;
        target = open_addr[open_depth];
        prog_len++;
        last_op = op;
        last_count = 1;
        add(KIND_WRITE, target, OP_OPEN, OPND_W'(here), ERR_NONE, 1'b0);
        add(KIND_WRITE, here, OP_CLOSE, OPND_W'(target), ERR_NONE, 1'b1);
      end
    endfunction

    function void field_check(input string field, input logic [OPND_W-1:0] want,
                              input logic [OPND_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_write(input store_write_t got);
      store_write_t want;
      checked++;
      if (pending_writes.size() == 0) begin
        $error("unexpected result: kind %0d addr %0h opcode %0d", got.kind, got.addr, got.op);
        failures++;
        return;
      end
      want = pending_writes.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("write_address", want.addr, got.addr);
      field_check("opcode", want.op, got.op);
      field_check("operand", want.operand, got.operand);
      field_check("error_code", want.err, got.err);
      field_check("last_of_run", want.last, got.last);
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1690;
  localparam int CALM_ITEMS   = 250;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [BYTE_W-1:0]        in_source_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_kind;
  logic [ADDR_W-1:0]        out_write_address;
  logic [OP_W-1:0]          out_opcode;
  logic signed [OPND_W-1:0] out_operand;
  logic [ERR_W-1:0]         out_error_code;
  logic                     out_last_of_run;

  compile_checker sb = new;

  int quiet_cycles = 0;
  int sent_items = 0;
  int gen_depth = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_req = 1'b0;

  logic [BYTE_W-1:0] run_chars [4] = '{CH_LEFT, CH_RIGHT, CH_INC, CH_DEC};
  logic [BYTE_W-1:0] directed [22] = '{8'h00, 8'hFF, 8'h61, CH_INC, CH_INC, CH_DEC, CH_LEFT,
                                       CH_LEFT, CH_RIGHT, CH_OUT, CH_OUT, CH_IN, CH_OPEN,
                                       CH_OPEN, CH_CLOSE, CH_INC, CH_CLOSE, CH_CLOSE, CH_OPEN,
                                       CH_CLOSE, CH_LEFT, 8'h80};

  loop_matching_opcode_compressor_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_source_byte    (in_source_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_write_address (out_write_address),
    .out_opcode        (out_opcode),
    .out_operand       (out_operand),
    .out_error_code    (out_error_code),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_write({out_kind, out_write_address, out_opcode, out_operand, out_error_code,
                        out_last_of_run});
      end
      if (in_valid && in_ready) sb.take_byte(in_source_byte);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      gap = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] ch);
    logic [OP_W-1:0] op;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_byte <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    if (decode_command(ch, op)) begin
      if (op == OP_OPEN && gen_depth < NEST_DEPTH_DEF) gen_depth++;
      else if (op == OP_CLOSE && gen_depth > 0) gen_depth--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_writes.size() != 0);
  endtask

  initial begin
    int n;
    int pick;
    int base;
    bit held;
    bit paused;
    logic [BYTE_W-1:0] ch;
    held = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i]);
    drain();

    // nest to the limit, one open too many, then unwind
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (NEST_DEPTH_DEF + 1) send_byte(CH_OPEN);
    send_byte(CH_INC);
    repeat (NEST_DEPTH_DEF) send_byte(CH_CLOSE);
    drain();

    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (sent_items - base > RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if ($urandom_range(0, 59) == 0) begin
        send_idle = $urandom_range(0, 1);
        recv_idle = $urandom_range(0, 1);
      end
      if (!held && sent_items - base > 600) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent_items - base > 1200) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        ch = run_chars[$urandom_range(0, 3)];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        repeat (n) send_byte(ch);
      end else if (pick < 45) begin
        send_byte($urandom_range(0, 1) ? CH_OUT : CH_IN);
      end else if (pick < 62) begin
        send_byte(gen_depth < 10 ? CH_OPEN : CH_CLOSE);
      end else if (pick < 80) begin
        send_byte((gen_depth > 0 || $urandom_range(0, 4) == 0) ? CH_CLOSE : CH_OPEN);
      end else begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end

    // close what is still open
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (gen_depth) send_byte(CH_CLOSE);

    drain();
    repeat (20) @(posedge clk);
    $display("summary: %0d source bytes, %0d results checked, %0d error reports",
             sb.bytes_taken, sb.checked, sb.errors_expected);
    $display("summary: nesting reached %0d, store length %0d", sb.deepest, sb.prog_len);
    if (sb.failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== loop_matching_opcode_compressor_core.f =====
hdl/lmoc_pkg.sv
hdl/lmoc_ram.sv
hdl/loop_matching_opcode_compressor_core.sv
tb/tb.sv
